@@ src/iphc_pkg.sv @@
`timescale 1ns / 1ps

package iphc_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam logic [4:0]  LastPos     = 5'(HeaderBytes - 1);
  localparam logic [4:0]  DonePos     = 5'(HeaderBytes);

  localparam logic [7:0]  VersionIhl  = 8'h45;
  localparam logic [15:0] FragMask    = 16'h3FFF;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [3:0]  McastPrefix = 4'hE;

  // Byte positions inside the header that carry fields of interest.
  localparam logic [4:0]  PosVersion  = 5'd0;
  localparam logic [4:0]  PosFrag     = 5'd7;
  localparam logic [4:0]  PosTtl      = 5'd8;
  localparam logic [4:0]  PosProto    = 5'd9;
  localparam logic [4:0]  PosCsum     = 5'd11;
  localparam logic [4:0]  PosDest     = 5'd16;

  // Register addresses on the configuration port (word select bit).
  localparam logic RegLocalAddr = 1'b0;
  localparam logic RegNetMask   = 1'b1;

  typedef enum logic [2:0] {
    VerdictIcmp     = 3'd0,
    VerdictUdp      = 3'd1,
    VerdictOther    = 3'd2,
    VerdictVersion  = 3'd3,
    VerdictFragment = 3'd4,
    VerdictTtlZero  = 3'd5,
    VerdictBadDest  = 3'd6,
    VerdictBadCsum  = 3'd7
  } verdict_e;

  // Header facts gathered byte by byte, handed to the classifier.
  typedef struct packed {
    logic        version_bad;
    logic        frag_set;
    logic        ttl_zero;
    logic [7:0]  protocol;
    logic [15:0] csum;
    logic [15:0] sum;
    logic [31:0] dest;
  } hdr_facts_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

@@ src/iphc_classify.sv @@
`timescale 1ns / 1ps

module iphc_classify (
  input  iphc_pkg::hdr_facts_t facts_i,
  input  logic [31:0]          local_addr_i,
  input  logic [31:0]          net_mask_i,
  output iphc_pkg::verdict_e   verdict_o
);
  import iphc_pkg::*;

  logic [31:0] host;
  logic        dest_ok;

  assign host    = ~net_mask_i;
  assign dest_ok = (facts_i.dest == local_addr_i) || (&facts_i.dest) ||
                   ((facts_i.dest & host) == host) ||
                   (facts_i.dest[31:28] == McastPrefix);

  // Checks are ordered: the first failing one decides the verdict.
  always_comb begin
    if (facts_i.version_bad) begin
      verdict_o = VerdictVersion;
    end else if (facts_i.frag_set) begin
      verdict_o = VerdictFragment;
    end else if (facts_i.ttl_zero) begin
      verdict_o = VerdictTtlZero;
    end else if (!dest_ok) begin
      verdict_o = VerdictBadDest;
    end else if (facts_i.csum != ~facts_i.sum) begin
      verdict_o = VerdictBadCsum;
    end else if (facts_i.protocol == ProtoIcmp) begin
      verdict_o = VerdictIcmp;
    end else if (facts_i.protocol == ProtoUdp) begin
      verdict_o = VerdictUdp;
    end else begin
      verdict_o = VerdictOther;
    end
  end

endmodule

@@ src/ipv4_receive_header_check_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   hdr_byte_i, first_byte_i
// result    out        out_valid_o / out_ready_i verdict_o, protocol_o
// config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One header byte is taken per cycle while in_ready_o is high; the verdict appears in the result
// register in the cycle after the transfer of header byte 19.
// Reset clears the byte position, so bytes after reset count from byte 0.
// A waiting result only holds off the transfer of a header's last byte;
// all other bytes are taken while the result register is full.

module ipv4_receive_header_check_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          hdr_byte_i,
  input  logic                first_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output iphc_pkg::verdict_e  verdict_o,
  output logic [7:0]          protocol_o
);
  import iphc_pkg::*;

  logic [31:0] local_addr_q;
  logic [31:0] net_mask_q;

  logic [4:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic        ver_bad_q, ver_bad_d;
  logic        frag_q, frag_d;
  logic        ttl_zero_q, ttl_zero_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] csum_q, csum_d;
  logic [23:0] dest_q, dest_d;

  logic        out_valid_q;
  verdict_e    verdict_q;
  logic [7:0]  protocol_q;

  logic        accept;
  logic [4:0]  pos;
  logic        active;
  logic        finish;
  logic [15:0] word;
  hdr_facts_t  facts;
  verdict_e    verdict;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegNetMask) ? net_mask_q : local_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      net_mask_q   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegLocalAddr) begin
        local_addr_q <= pwdata;
      end else begin
        net_mask_q <= pwdata;
      end
    end
  end

  // Header gathering
  assign in_ready_o = !out_valid_q || out_ready_i || (pos_q != LastPos);
  assign accept     = in_valid_i && in_ready_o;
  assign pos        = first_byte_i ? '0 : pos_q;
  assign active     = pos < DonePos;
  assign finish     = accept && (pos == LastPos);
  assign word       = {pend_q, hdr_byte_i};

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    pend_d     = pend_q;
    ver_bad_d  = ver_bad_q;
    frag_d     = frag_q;
    ttl_zero_d = ttl_zero_q;
    proto_d    = proto_q;
    csum_d     = csum_q;
    dest_d     = dest_q;
    if (accept && active) begin
      pos_d = pos + 5'd1;
      if (!pos[0]) begin
        pend_d = hdr_byte_i;
      end else if (pos == PosCsum) begin
        csum_d = word;
      end else begin
        sum_d = ones_add(sum_q, word);
      end
      // Position 0 is reached only after reset or a start mark, so the sum restarts.
      if (pos == PosVersion) begin
        sum_d     = '0;
        ver_bad_d = hdr_byte_i != VersionIhl;
      end
      if (pos == PosFrag) begin
        frag_d = (word & FragMask) != '0;
      end
      if (pos == PosTtl) begin
        ttl_zero_d = hdr_byte_i == 8'd0;
      end
      if (pos == PosProto) begin
        proto_d = hdr_byte_i;
      end
      if (pos >= PosDest) begin
        dest_d = {dest_q[15:0], hdr_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      pend_q     <= '0;
      ver_bad_q  <= 1'b0;
      frag_q     <= 1'b0;
      ttl_zero_q <= 1'b0;
      proto_q    <= '0;
      csum_q     <= '0;
      dest_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      pend_q     <= pend_d;
      ver_bad_q  <= ver_bad_d;
      frag_q     <= frag_d;
      ttl_zero_q <= ttl_zero_d;
      proto_q    <= proto_d;
      csum_q     <= csum_d;
      dest_q     <= dest_d;
    end
  end

  // The last byte closes the final word and the destination in the same cycle.
  always_comb begin
    facts.version_bad = ver_bad_q;
    facts.frag_set    = frag_q;
    facts.ttl_zero    = ttl_zero_q;
    facts.protocol    = proto_q;
    facts.csum        = csum_q;
    facts.sum         = ones_add(sum_q, word);
    facts.dest        = {dest_q, hdr_byte_i};
  end

  iphc_classify u_classify (
    .facts_i      (facts),
    .local_addr_i (local_addr_q),
    .net_mask_i   (net_mask_q),
    .verdict_o    (verdict)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      verdict_q  <= verdict;
      protocol_q <= proto_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign protocol_o  = protocol_q;

endmodule
